>>> hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_STATS = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_BAD   = 2'd2,
		ST_RSVD  = 2'd3
	} st_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [16:0] alloc_size;
		logic [15:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] payload_offset;
		logic [16:0] total_bytes;
		logic [16:0] avail_bytes;
		logic [16:0] largest_free;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load_cfg;
		logic init;
		logic begin_req;
		logic rd;
		logic rd_next;
		logic eval;
		logic adv;
		logic acc;
		logic wr_cur;
		logic wr_split;
		logic set_st;
		st_t  st;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic fit;
		logic hit;
		logic used;
		logic last;
		logic split;
	} sts_t;

endpackage

>>> hw/rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// First-fit heap allocator. Requests (allocate, free, statistics) are taken one at a
// time; each allocate, free or statistics request walks the block chain from
// offset 0 through a block header memory with a registered read, reading and then
// evaluating each block visited. An allocate walks up to the fit and then writes a
// split remainder if one is made; a free walks up to the match and then reads the
// following block to absorb it when it is free; statistics visit every block in the
// heap. After reset or a heap size write the heap is rebuilt as a single free block.
// A new request is accepted while the previous result waits.
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 40,
	parameter int MIN_SPLIT    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (op_t'(req.req_type)),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ffha_dp #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MIN_SPLIT    (MIN_SPLIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

endmodule

>>> hw/rtl/ffha_ram.sv
`timescale 1ns / 1ps
module ffha_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/ffha_dp.sv
`timescale 1ns / 1ps
module ffha_dp import ffha_pkg::*; #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 40,
	parameter int MIN_SPLIT    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [16:0] cfg_data,
	input  req_t        req,
	output rsp_t        rsp
);

	localparam int OW    = $clog2(HEAP_BYTES) + 1;
	localparam int DEPTH = HEAP_BYTES / 8;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = (OW > 18) ? OW : 18;
	localparam int PW    = (OW + 1 > 16) ? OW + 1 : 16;
	localparam int CW    = (OW > 17) ? OW : 17;
	localparam logic [OW-1:0] HDR = OW'(HEADER_BYTES);

	logic [OW-1:0] heap_q, cur_q, size_q, avail_q, big_q;
	// a request near the field limit rounds up to 2^17
	logic [17:0]   need_q;
	logic [15:0]   p_q, off_q;
	op_t           op_q;
	st_t           st_q;
	logic          last_q;
	rsp_t          rsp_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [OW:0]   wdata, rdata;
	logic          rd_used;
	logic [OW-1:0] rd_size;
	logic [OW:0]   next_rd, pay, nx, spl;
	logic [PW-1:0] pay_w;
	logic [NW-1:0] left, left_q;
	logic [17:0]   need_rnd;
	logic [31:0]   clamp;
	logic [CW-1:0] tot_w, av_w, big_w;
	logic          merge;

	assign rd_used  = rdata[OW];
	assign rd_size  = rdata[OW-1:0];
	assign next_rd  = {1'b0, cur_q} + {1'b0, HDR} + {1'b0, rd_size};
	assign nx       = {1'b0, cur_q} + {1'b0, HDR} + {1'b0, size_q};
	assign pay      = {1'b0, cur_q} + {1'b0, HDR};
	assign pay_w    = PW'(pay);
	assign spl      = pay + (OW + 1)'(need_q);
	assign left     = NW'(rd_size) - NW'(need_q);
	assign left_q   = NW'(size_q) - NW'(need_q);
	assign need_rnd = ({1'b0, req.alloc_size} + 18'd7) & ~18'd7;
	assign merge    = !last_q && !rd_used;

	assign sts.op    = op_q;
	assign sts.fit   = !rd_used && (NW'(rd_size) >= NW'(need_q));
	assign sts.hit   = pay_w == PW'(p_q);
	assign sts.used  = rd_used;
	assign sts.last  = next_rd >= {1'b0, heap_q};
	assign sts.split = (32'(left) >= 32'(MIN_SPLIT)) && (32'(left) >= 32'(HEADER_BYTES));

	always_comb begin
		if (32'(cfg_data) < 32'd128) begin
			clamp = 32'd128;
		end else if (32'(cfg_data) > 32'(HEAP_BYTES)) begin
			clamp = 32'(HEAP_BYTES);
		end else begin
			clamp = 32'(cfg_data);
		end
	end

	// one write port: init, current block, or split remainder
	always_comb begin
		we    = cmd.init | cmd.wr_cur | cmd.wr_split;
		waddr = cur_q[AW+2:3];
		wdata = {1'b0, heap_q - HDR};
		if (cmd.wr_split) begin
			waddr = spl[AW+2:3];
			wdata = {1'b0, OW'(left_q - NW'(HEADER_BYTES))};
		end else if (cmd.wr_cur) begin
			if (op_q == OP_ALLOC) begin
				wdata = {1'b1, sts.split ? OW'(need_q) : rd_size};
			end else begin
				wdata = {1'b0, merge ? (size_q + rd_size + HDR) : size_q};
			end
		end else if (cmd.init) begin
			waddr = '0;
		end
		re    = cmd.rd | cmd.rd_next;
		raddr = cmd.rd_next ? nx[AW+2:3] : cur_q[AW+2:3];
	end

	ffha_ram #(.WIDTH(OW + 1), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= OW'(HEAP_BYTES);
		end else if (cmd.load_cfg) begin
			heap_q <= OW'(clamp);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_req) begin
			op_q    <= op_t'(req.req_type);
			need_q  <= need_rnd;
			p_q     <= req.free_offset;
			cur_q   <= '0;
			avail_q <= '0;
			big_q   <= '0;
			st_q    <= ST_OK;
			off_q   <= '0;
		end
		if (cmd.eval) begin
			size_q <= rd_size;
			last_q <= sts.last;
		end
		if (cmd.adv) begin
			cur_q <= next_rd[OW-1:0];
		end
		if (cmd.acc && !rd_used) begin
			avail_q <= avail_q + rd_size;
			if (rd_size > big_q) begin
				big_q <= rd_size;
			end
		end
		if (cmd.wr_cur && op_q == OP_ALLOC) begin
			off_q <= pay_w[15:0];
		end
		if (cmd.set_st) begin
			st_q <= cmd.st;
		end
		if (cmd.emit) begin
			rsp_q.status         <= st_q;
			rsp_q.payload_offset <= off_q;
			rsp_q.total_bytes    <= (op_q == OP_STATS) ? tot_w[16:0] : 17'd0;
			rsp_q.avail_bytes    <= av_w[16:0];
			rsp_q.largest_free   <= big_w[16:0];
		end
	end

	assign tot_w = CW'(heap_q);
	assign av_w  = CW'(avail_q);
	assign big_w = CW'(big_q);
	assign rsp   = rsp_q;

endmodule

>>> hw/rtl/ffha_ctrl.sv
`timescale 1ns / 1ps
module ffha_ctrl import ffha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  op_t  req_op,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  logic cfg_valid,
	output logic cfg_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [7:0] {
		S_INIT = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_RD   = 8'b0000_0100,
		S_EV   = 8'b0000_1000,
		S_NRD  = 8'b0001_0000,
		S_NEV  = 8'b0010_0000,
		S_WSPL = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   take;

	assign cfg_ready = state_q == S_IDLE;
	assign req_stall = (state_q != S_IDLE) || cfg_valid;
	assign take      = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.st  = ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_valid) begin
					cmd.load_cfg = 1'b1;
					state_d      = S_INIT;
				end else if (take) begin
					cmd.begin_req = 1'b1;
					state_d       = (req_op == OP_NONE) ? S_DONE : S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				cmd.eval = 1'b1;
				case (sts.op)
					OP_ALLOC: begin
						if (sts.fit) begin
							cmd.wr_cur = 1'b1;
							state_d    = sts.split ? S_WSPL : S_DONE;
						end else if (sts.last) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_NOFIT;
							state_d    = S_DONE;
						end else begin
							cmd.adv = 1'b1;
							state_d = S_RD;
						end
					end
					OP_FREE: begin
						if (sts.hit && sts.used) begin
							state_d = S_NRD;
						end else if (sts.hit || sts.last) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_BAD;
							state_d    = S_DONE;
						end else begin
							cmd.adv = 1'b1;
							state_d = S_RD;
						end
					end
					default: begin
						cmd.acc = 1'b1;
						cmd.adv = !sts.last;
						state_d = sts.last ? S_DONE : S_RD;
					end
				endcase
			end
			S_NRD: begin
				cmd.rd_next = 1'b1;
				state_d     = S_NEV;
			end
			S_NEV: begin
				// free the block, absorbing the following one when it is free
				cmd.wr_cur = 1'b1;
				state_d    = S_DONE;
			end
			S_WSPL: begin
				cmd.wr_split = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_cur |-> (state_q == S_EV || state_q == S_NEV))
		else $error("block write outside evaluation");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q != S_IDLE)
		else $error("accepted request did not start");
	a_split_after_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WSPL |-> $past(cmd.wr_cur) && sts.op == OP_ALLOC)
		else $error("split without allocate");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> rsp_valid)
		else $error("result not presented");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import ffha_pkg::*;

	localparam int HEAP_MAX    = 65536;
	localparam int HDR_BYTES   = 40;
	localparam int SPLIT_MIN   = 64;
	localparam int BLOCK_LIMIT = HEAP_MAX / 8 + 2;
	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [16:0] cfg_data;

	first_fit_heap_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// shadow of the block chain
	int unsigned blk_start[$];
	int unsigned blk_size[$];
	bit          blk_used[$];
	int unsigned heap_size;

	req_t        pending_reqs[$];
	rsp_t        expected_rsps[$];
	logic [15:0] granted_offsets[$];
	int          mismatches = 0;
	int          checked = 0;
	int          cfg_writes = 0;
	int          cycles = 0;

	function automatic void heap_rebuild(logic [16:0] bytes);
		int unsigned h;
		h = bytes;
		if (h < 128) h = 128;
		if (h > HEAP_MAX) h = HEAP_MAX;
		heap_size = h;
		blk_start = {0};
		blk_size  = {h - HDR_BYTES};
		blk_used  = {1'b0};
	endfunction

	function automatic rsp_t heap_predict(req_t r);
		rsp_t        o;
		int unsigned need;
		int unsigned left;
		int unsigned avail;
		int unsigned big;
		int          i;
		o = '0;
		case (op_t'(r.req_type))
			OP_ALLOC: begin
				need = (int'(r.alloc_size) + 7) & 32'hFFFF_FFF8;
				for (i = 0; i < blk_start.size(); i++)
					if (!blk_used[i] && blk_size[i] >= need) break;
				if (i >= blk_start.size()) begin
					o.status = ST_NOFIT;
				end else begin
					left = blk_size[i] - need;
					blk_used[i] = 1'b1;
					if (left >= SPLIT_MIN && left >= HDR_BYTES &&
					    blk_start.size() < BLOCK_LIMIT) begin
						blk_start.insert(i + 1, blk_start[i] + HDR_BYTES + need);
						blk_size.insert(i + 1, left - HDR_BYTES);
						blk_used.insert(i + 1, 1'b0);
						blk_size[i] = need;
					end
					o.status = ST_OK;
					o.payload_offset = 16'(blk_start[i] + HDR_BYTES);
					granted_offsets.push_back(o.payload_offset);
				end
			end
			OP_FREE: begin
				for (i = 0; i < blk_start.size(); i++)
					if (blk_start[i] + HDR_BYTES == r.free_offset) break;
				if (i >= blk_start.size() || !blk_used[i]) begin
					o.status = ST_BAD;
				end else begin
					blk_used[i] = 1'b0;
					// merge forward only
					if (i + 1 < blk_start.size() && !blk_used[i + 1]) begin
						blk_size[i] = blk_size[i] + blk_size[i + 1] + HDR_BYTES;
						blk_start.delete(i + 1);
						blk_size.delete(i + 1);
						blk_used.delete(i + 1);
					end
					o.status = ST_OK;
				end
			end
			OP_STATS: begin
				avail = 0;
				big = 0;
				foreach (blk_start[k]) begin
					if (!blk_used[k]) begin
						avail += blk_size[k];
						if (blk_size[k] > big) big = blk_size[k];
					end
				end
				o.status = ST_OK;
				o.total_bytes = 17'(heap_size);
				o.avail_bytes = 17'(avail);
				o.largest_free = 17'(big);
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string field, int unsigned got, int unsigned want);
		$display("mismatch on %s at cycle %0d: got %0d, expected %0d", field, cycles, got, want);
		mismatches++;
	endtask

	// request driver: bursts with random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req_valid && !req_stall) expected_rsps.push_back(heap_predict(req));
			if (!(req_valid && req_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor with its own stall pattern
	int stall_pct;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_pct = 0;
		end else begin
			rsp_t want;
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$display("unexpected transaction at cycle %0d", cycles);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					checked++;
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.payload_offset !== want.payload_offset)
						report_mismatch("payload_offset", rsp.payload_offset, want.payload_offset);
					if (rsp.total_bytes !== want.total_bytes)
						report_mismatch("total_bytes", rsp.total_bytes, want.total_bytes);
					if (rsp.avail_bytes !== want.avail_bytes)
						report_mismatch("avail_bytes", rsp.avail_bytes, want.avail_bytes);
					if (rsp.largest_free !== want.largest_free)
						report_mismatch("largest_free", rsp.largest_free, want.largest_free);
				end
			end
			if (cycles % 256 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic req_t make_req(op_t op, int unsigned size, int unsigned off);
		req_t r;
		r.req_type = op;
		r.alloc_size = 17'(size);
		r.free_offset = 16'(off);
		return r;
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_heap_size(logic [16:0] bytes);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= bytes;
		do @(posedge clk); while (!cfg_ready);
		heap_rebuild(bytes);
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int count, int unsigned size_max);
		int unsigned pick;
		int          idx;
		for (int n = 0; n < count; n++) begin
			// refill in small chunks so frees can target live grants
			if (n % 8 == 0) wait_idle();
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if ($urandom_range(0, 19) == 0)
					pending_reqs.push_back(make_req(OP_ALLOC, $urandom_range(0, 131071), 0));
				else
					pending_reqs.push_back(make_req(OP_ALLOC, $urandom_range(0, size_max),
						$urandom));
			end else if (pick < 88) begin
				if (granted_offsets.size() > 0 && $urandom_range(0, 4) != 0) begin
					idx = $urandom_range(0, granted_offsets.size() - 1);
					pending_reqs.push_back(make_req(OP_FREE, $urandom,
						granted_offsets[idx]));
					granted_offsets.delete(idx);
				end else begin
					pending_reqs.push_back(make_req(OP_FREE, $urandom, $urandom_range(0, 65535)));
				end
			end else if (pick < 97) begin
				pending_reqs.push_back(make_req(OP_STATS, $urandom, $urandom));
			end else begin
				pending_reqs.push_back(make_req(OP_NONE, $urandom, $urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		heap_rebuild(17'd65536);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every request type, bad frees, no fit
		pending_reqs.push_back(make_req(OP_STATS, 0, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 0, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 1, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 65536, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 131071, 65535));
		pending_reqs.push_back(make_req(OP_FREE, 0, 65535));
		pending_reqs.push_back(make_req(OP_FREE, 0, 0));
		pending_reqs.push_back(make_req(OP_FREE, 0, 40));
		pending_reqs.push_back(make_req(OP_FREE, 0, 40));
		pending_reqs.push_back(make_req(OP_FREE, 0, 80));
		pending_reqs.push_back(make_req(OP_STATS, 131071, 65535));
		pending_reqs.push_back(make_req(OP_NONE, 131071, 65535));
		pending_reqs.push_back(make_req(OP_ALLOC, 65000, 0));
		pending_reqs.push_back(make_req(OP_STATS, 0, 0));
		granted_offsets.delete();

		// smallest heap: whole-block grants on a tiny leftover
		write_heap_size(17'd128);
		pending_reqs.push_back(make_req(OP_ALLOC, 40, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 1, 0));
		pending_reqs.push_back(make_req(OP_STATS, 0, 0));
		pending_reqs.push_back(make_req(OP_FREE, 0, 40));
		pending_reqs.push_back(make_req(OP_ALLOC, 88, 0));
		pending_reqs.push_back(make_req(OP_ALLOC, 89, 0));
		granted_offsets.delete();
		random_phase(60, 100);

		write_heap_size(17'd0);
		random_phase(60, 96);
		write_heap_size(17'd1024);
		random_phase(150, 300);
		write_heap_size(17'd131071);
		random_phase(120, 4096);
		write_heap_size(17'd4096);
		random_phase(180, 400);
		write_heap_size(17'd65536);
		random_phase(150, 2000);
		write_heap_size(17'd300);
		random_phase(100, 200);

		wait_idle();
		repeat (50) @(posedge clk);
		$display("checked %0d responses over %0d heap size settings, %0d cycles",
			checked, cfg_writes + 1, cycles);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches,
				expected_rsps.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/ffha_dp.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator.sv
tb/testbench.sv
